// ===== rtl/core/u16tx_pkg.sv =====
// Shared types and constants of the 16550-style transmit register block.
// No dependencies; imported by the top level.
package u16tx_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	// word-spaced register map
	localparam logic [6:0] REG_THR_DLL = 7'h00;
	localparam logic [6:0] REG_IER_DLM = 7'h04;
	localparam logic [6:0] REG_FCR_IIR = 7'h08;
	localparam logic [6:0] REG_LCR     = 7'h0c;
	localparam logic [6:0] REG_MCR     = 7'h10;
	localparam logic [6:0] REG_LSR     = 7'h14;
	localparam logic [6:0] REG_USR     = 7'h7c;

	localparam logic [7:0] IIR_FIFO_ON  = 8'hC1;
	localparam logic [7:0] IIR_FIFO_OFF = 8'h01;
	localparam logic [7:0] LSR_THRE_TEMT = 8'h60;
	localparam logic [7:0] LSR_THRE      = 8'h20;

	localparam logic [11:0] SHIFT_IDLE = 12'hFFF;
	localparam logic [3:0]  MAX_FRAME_BITS = 4'd11;

	// LCR / MCR bit positions
	localparam int LCR_DLAB  = 7;
	localparam int LCR_BREAK = 6;
	localparam int LCR_STOP2 = 2;
	localparam int MCR_LOOP  = 4;

endpackage

// ===== rtl/core/u16tx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module u16tx_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/uart_16550_transmit_registers.sv =====
// Top level: 16550-style UART transmitter behind word-spaced registers.
// Depends on u16tx_pkg and u16tx_ram.
//
// Channel   Dir  tdata                                   tuser
// s_axis    in   [6:0] reg_offset, [14:7] write_data     [1:0] command
// m_axis    out  [7:0] read_data, [8] tx_line, [9] busy  -
//
// Flow: one item per clock while results are taken; a result passes the input
// register, then the result register, before it is offered. All the work
// of an item is one pass of next-state logic between the two, writing the
// state registers and the transmit FIFO RAM in the same edge.
// Reset: asynchronous, active low; clears control state and registers.
// The FIFO RAM is not cleared: the count and pointer keep stale entries
// out of reach.
// Stalls: a held result only stops the input register when it is full
// too, so one further item is always taken while a result waits.
module uart_16550_transmit_registers
	import u16tx_pkg::*;
#(
	parameter int FIFO_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [6:0] reg_offset, [14:7] write_data, [15] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [7:0] read_data, [8] tx_line, [9] tx_busy
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	// ---- input register ----
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [6:0] off_s1;
	logic [7:0] wdata_s1;

	// ---- result register ----
	logic       out_valid_q;
	logic [7:0] out_rdata_q;
	logic       out_line_q;
	logic       out_busy_q;

	logic advance;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1   <= s_axis_tuser;
			off_s1   <= s_axis_tdata[6:0];
			wdata_s1 <= s_axis_tdata[14:7];
		end
	end

	// ---- architectural state ----
	logic [7:0]       dll_q, dlm_q, lcr_q;
	logic [3:0]       ier_q;
	logic             fifo_en_q;
	logic [4:0]       mcr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] rp_q;
	logic [11:0]      shift_q;
	logic [3:0]       bits_q;
	logic [15:0]      baud_q;
	logic [3:0]       six_q;

	logic [7:0]       dll_nx, dlm_nx, lcr_nx;
	logic [3:0]       ier_nx;
	logic             fifo_en_nx;
	logic [4:0]       mcr_nx;
	logic [CNT_W-1:0] cnt_nx;
	logic [PTR_W-1:0] rp_nx;
	logic [11:0]      shift_nx;
	logic [3:0]       bits_nx;
	logic [15:0]      baud_nx;
	logic [3:0]       six_nx;
	logic [7:0]       rdata_nx;
	logic             push;

	// FIFO storage: head byte comes from the RAM, or from the bypass
	// register when the head was written in the previous cycle.
	logic [PTR_W-1:0] ram_raddr;
	logic [PTR_W-1:0] waddr;
	logic             ram_we;
	logic [7:0]       ram_rdata;
	logic             bypass_q;
	logic [7:0]       bypass_data_q;
	logic [7:0]       head;

	assign head = bypass_q ? bypass_data_q : ram_rdata;

	logic             dlab;
	logic [15:0]      divisor;
	logic [CNT_W-1:0] capacity;
	logic [SUM_W-1:0] wsum;
	logic [PTR_W-1:0] rp_inc;
	logic [7:0]       data_mask;
	logic [7:0]       frame_byte;

	assign dlab      = lcr_q[LCR_DLAB];
	assign divisor   = {dlm_q, dll_q};
	assign capacity  = fifo_en_q ? CNT_W'(FIFO_DEPTH) : CNT_W'(1);
	assign wsum      = SUM_W'(rp_q) + SUM_W'(cnt_q);
	assign waddr     = (wsum >= SUM_W'(FIFO_DEPTH)) ? PTR_W'(wsum - SUM_W'(FIFO_DEPTH))
	                                                : PTR_W'(wsum);
	assign rp_inc    = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	// 5..8 data bits
	assign data_mask  = 8'hFF >> (2'd3 - lcr_q[1:0]);
	assign frame_byte = head & data_mask;

	always_comb begin
		dll_nx     = dll_q;
		dlm_nx     = dlm_q;
		lcr_nx     = lcr_q;
		ier_nx     = ier_q;
		fifo_en_nx = fifo_en_q;
		mcr_nx     = mcr_q;
		cnt_nx     = cnt_q;
		rp_nx      = rp_q;
		shift_nx   = shift_q;
		bits_nx    = bits_q;
		baud_nx    = baud_q;
		six_nx     = six_q;
		rdata_nx   = 8'h00;
		push       = 1'b0;

		case (cmd_t'(cmd_s1))
			CMD_READ: begin
				unique case (off_s1)
					REG_THR_DLL: rdata_nx = dlab ? dll_q : 8'h00;
					REG_IER_DLM: rdata_nx = dlab ? dlm_q : {4'h0, ier_q};
					REG_FCR_IIR: rdata_nx = fifo_en_q ? IIR_FIFO_ON : IIR_FIFO_OFF;
					REG_LCR:     rdata_nx = lcr_q;
					REG_MCR:     rdata_nx = {3'b000, mcr_q};
					REG_LSR: begin
						if (cnt_q != '0) begin
							rdata_nx = 8'h00;
						end else begin
							rdata_nx = (bits_q == 4'd0) ? LSR_THRE_TEMT : LSR_THRE;
						end
					end
					REG_USR:     rdata_nx = {7'h00, bits_q != 4'd0};
					default:     rdata_nx = 8'h00;
				endcase
			end
			CMD_WRITE: begin
				unique case (off_s1)
					REG_THR_DLL: begin
						if (dlab) begin
							dll_nx = wdata_s1;
						end else if (cnt_q < capacity) begin
							push   = 1'b1;
							cnt_nx = cnt_q + 1'b1;
						end
					end
					REG_IER_DLM: begin
						if (dlab) begin
							dlm_nx = wdata_s1;
						end else begin
							ier_nx = wdata_s1[3:0];
						end
					end
					REG_FCR_IIR: begin
						// enable change or clear bit empties the FIFO
						if ((wdata_s1[0] != fifo_en_q) || wdata_s1[2]) begin
							cnt_nx = '0;
							rp_nx  = '0;
						end
						fifo_en_nx = wdata_s1[0];
					end
					REG_LCR: lcr_nx = wdata_s1;
					REG_MCR: mcr_nx = wdata_s1[4:0];
					default: ;
				endcase
			end
			CMD_TICK: begin
				if (divisor != 16'd0) begin
					if ({1'b0, baud_q} + 17'd1 >= {1'b0, divisor}) begin
						baud_nx = '0;
						// baud period boundary
						if (bits_q != 4'd0) begin
							six_nx = six_q + 1'b1;
							if (six_nx == 4'd0) begin
								shift_nx = {1'b1, shift_q[11:1]};
								bits_nx  = bits_q - 1'b1;
							end
						end else if (cnt_q != '0) begin
							rp_nx    = rp_inc;
							cnt_nx   = cnt_q - 1'b1;
							shift_nx = (SHIFT_IDLE & ~{3'b000, data_mask, 1'b1})
							         | {3'b000, frame_byte, 1'b0};
							bits_nx  = 4'd6 + {2'b00, lcr_q[1:0]}
							         + (lcr_q[LCR_STOP2] ? 4'd2 : 4'd1);
							six_nx   = '0;
						end
					end else begin
						baud_nx = baud_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign ram_we    = advance && push;
	assign ram_raddr = advance ? rp_nx : rp_q;

	u16tx_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH),
		.ADDR_W(PTR_W)
	) u_fifo_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata_s1),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
		end else begin
			bypass_q <= ram_we && (waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		bypass_data_q <= wdata_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dll_q     <= '0;
			dlm_q     <= '0;
			lcr_q     <= '0;
			ier_q     <= '0;
			fifo_en_q <= 1'b0;
			mcr_q     <= '0;
			cnt_q     <= '0;
			rp_q      <= '0;
			shift_q   <= SHIFT_IDLE;
			bits_q    <= '0;
			baud_q    <= '0;
			six_q     <= '0;
		end else if (advance) begin
			dll_q     <= dll_nx;
			dlm_q     <= dlm_nx;
			lcr_q     <= lcr_nx;
			ier_q     <= ier_nx;
			fifo_en_q <= fifo_en_nx;
			mcr_q     <= mcr_nx;
			cnt_q     <= cnt_nx;
			rp_q      <= rp_nx;
			shift_q   <= shift_nx;
			bits_q    <= bits_nx;
			baud_q    <= baud_nx;
			six_q     <= six_nx;
		end
	end

	// ---- result register ----
	logic line_nx;
	// break forces low, loopback holds high, else shifter LSB
	assign line_nx = lcr_nx[LCR_BREAK] ? 1'b0 : (mcr_nx[MCR_LOOP] ? 1'b1 : shift_nx[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_rdata_q <= rdata_nx;
			out_line_q  <= line_nx;
			out_busy_q  <= bits_nx != 4'd0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'h00, out_busy_q, out_line_q, out_rdata_q};

`ifndef NO_ASSERTIONS
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= capacity || (fifo_en_q == 1'b0 && cnt_q == '0))
		else $error("FIFO count above capacity");

	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= MAX_FRAME_BITS)
		else $error("frame bit count out of range");

	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with result register empty");

	a_idle_line: assert property (@(posedge clk) disable iff (!arst_n)
		(bits_q == 4'd0) |-> (shift_q == SHIFT_IDLE))
		else $error("shifter not idle with no frame in flight");
`endif

endmodule
